@@ design/xwhc_pkg.sv @@
// ----------------------------------------------------------------------------
// XOR Walsh-Hadamard convolution: shared types and constants
// Command bundle from controller to datapath, write-data selects, register
// indexes, mode codes and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package xwhc_pkg;

	// Parameter defaults
	localparam int MAX_LENGTH_DEF = 1024;
	localparam int INPUT_BITS_DEF = 16;

	// Fixed field widths
	localparam int RESULT_W   = 64;
	localparam int MODE_W     = 2;
	localparam int LOG_W      = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOG_SIZE = 1'b1;

	// Mode codes; the unused code runs as forward transform
	localparam logic [MODE_W-1:0] MODE_FWD  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_INV  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CONV = 2'd2;

	// Request kinds on the input stream
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_READ = 1'b1;

	// Work RAM write-data select
	typedef enum logic [2:0] {
		WSEL_LOAD  = 3'd0,
		WSEL_SUM   = 3'd1,
		WSEL_DIFF  = 3'd2,
		WSEL_PROD  = 3'd3,
		WSEL_SHIFT = 3'd4
	} wsel_t;

	// Partial-product step of the shared 32x32 multiplier
	typedef enum logic [1:0] {
		MUL_IDLE = 2'd0,
		MUL_LO   = 2'd1,
		MUL_HI_A = 2'd2,
		MUL_HI_B = 2'd3
	} mul_op_t;

	// Controller to datapath command bundle
	typedef struct packed {
		logic             we_a;
		logic             we_b;
		wsel_t            wsel;
		logic             src_b;
		mul_op_t          mul_op;
		logic             out_load;
		logic             out_last;
		logic [LOG_W-1:0] shift_amt;
	} cmd_t;

endpackage

`default_nettype wire

@@ design/xwhc_ram.sv @@
// ----------------------------------------------------------------------------
// Generic work RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module xwhc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr0,
	input  wire logic [$clog2(DEPTH)-1:0] raddr1,
	output logic      [WIDTH-1:0]         rdata0,
	output logic      [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, then register both reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

`default_nettype wire

@@ design/xwhc_dpath.sv @@
// ----------------------------------------------------------------------------
// XOR Walsh-Hadamard convolution datapath
// Work RAMs for both vectors, butterfly adder, shared 32x32 multiplier,
// arithmetic shifter and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module xwhc_dpath import xwhc_pkg::*; #(
	parameter int MAX_LENGTH = MAX_LENGTH_DEF,
	parameter int INPUT_BITS = INPUT_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cmd_t                          cmd,
	input  wire logic [$clog2(MAX_LENGTH)-1:0] rd_addr0,
	input  wire logic [$clog2(MAX_LENGTH)-1:0] rd_addr1,
	input  wire logic [$clog2(MAX_LENGTH)-1:0] wr_addr,
	input  wire logic [INPUT_BITS-1:0]         load_a,
	input  wire logic [INPUT_BITS-1:0]         load_b,
	input  wire logic                          out_ready,
	output logic                               out_valid,
	output logic      [RESULT_W-1:0]           out_data,
	output logic                               out_last
);

	localparam int LOG_MAX = $clog2(MAX_LENGTH + 1) - 1;
	// Transformed b needs input width plus one bit per butterfly stage, plus one more
	localparam int BW      = INPUT_BITS + LOG_MAX + 1;

	logic [RESULT_W-1:0] rd_a0, rd_a1;
	logic [BW-1:0]       rd_b0, rd_b1;
	logic [RESULT_W-1:0] b0_ext, b1_ext;
	logic [RESULT_W-1:0] src0, src1, sum, shr;
	logic [RESULT_W-1:0] wdata_a;
	logic [BW-1:0]       wdata_b;
	logic [RESULT_W-1:0] diff_q;
	logic [RESULT_W-1:0] a_q, b_q, prod_q, acc_q, prod_wr;
	logic [31:0]         mul_x, mul_y;
	logic [RESULT_W-1:0] mul_p;
	logic                out_valid_q, out_last_q;
	logic [RESULT_W-1:0] out_data_q;

	xwhc_ram #(.WIDTH(RESULT_W), .DEPTH(MAX_LENGTH)) u_ram_a (
		.clk    (clk),
		.we     (cmd.we_a),
		.waddr  (wr_addr),
		.wdata  (wdata_a),
		.raddr0 (rd_addr0),
		.raddr1 (rd_addr1),
		.rdata0 (rd_a0),
		.rdata1 (rd_a1)
	);

	xwhc_ram #(.WIDTH(BW), .DEPTH(MAX_LENGTH)) u_ram_b (
		.clk    (clk),
		.we     (cmd.we_b),
		.waddr  (wr_addr),
		.wdata  (wdata_b),
		.raddr0 (rd_addr0),
		.raddr1 (rd_addr1),
		.rdata0 (rd_b0),
		.rdata1 (rd_b1)
	);

	// Butterfly operands from the selected vector
	assign b0_ext = {{(RESULT_W-BW){rd_b0[BW-1]}}, rd_b0};
	assign b1_ext = {{(RESULT_W-BW){rd_b1[BW-1]}}, rd_b1};
	assign src0   = cmd.src_b ? b0_ext : rd_a0;
	assign src1   = cmd.src_b ? b1_ext : rd_a1;
	assign sum    = src0 + src1;
	assign shr    = RESULT_W'($signed(rd_a0) >>> cmd.shift_amt);

	// Hold the difference for the second write of the butterfly
	always_ff @(posedge clk) begin
		diff_q <= src0 - src1;
	end

	// Select multiplier operands for each partial product
	always_comb begin
		case (cmd.mul_op)
			MUL_LO: begin
				mul_x = rd_a0[31:0];
				mul_y = b0_ext[31:0];
			end
			MUL_HI_A: begin
				mul_x = a_q[63:32];
				mul_y = b_q[31:0];
			end
			MUL_HI_B: begin
				mul_x = a_q[31:0];
				mul_y = b_q[63:32];
			end
			default: begin
				mul_x = a_q[31:0];
				mul_y = b_q[31:0];
			end
		endcase
	end

	assign mul_p   = mul_x * mul_y;
	assign prod_wr = acc_q + {prod_q[31:0], 32'b0};

	// Accumulate the low 64 bits of the product
	always_ff @(posedge clk) begin
		case (cmd.mul_op)
			MUL_LO: begin
				a_q    <= rd_a0;
				b_q    <= b0_ext;
				prod_q <= mul_p;
			end
			MUL_HI_A: begin
				acc_q  <= prod_q;
				prod_q <= mul_p;
			end
			MUL_HI_B: begin
				acc_q  <= prod_wr;
				prod_q <= mul_p;
			end
			default: ;
		endcase
	end

	// Write data for both RAMs
	always_comb begin
		case (cmd.wsel)
			WSEL_LOAD: begin
				wdata_a = {{(RESULT_W-INPUT_BITS){load_a[INPUT_BITS-1]}}, load_a};
				wdata_b = {{(BW-INPUT_BITS){load_b[INPUT_BITS-1]}}, load_b};
			end
			WSEL_SUM: begin
				wdata_a = sum;
				wdata_b = sum[BW-1:0];
			end
			WSEL_DIFF: begin
				wdata_a = diff_q;
				wdata_b = diff_q[BW-1:0];
			end
			WSEL_PROD: begin
				wdata_a = prod_wr;
				wdata_b = prod_wr[BW-1:0];
			end
			WSEL_SHIFT: begin
				wdata_a = shr;
				wdata_b = shr[BW-1:0];
			end
			default: begin
				wdata_a = '0;
				wdata_b = '0;
			end
		endcase
	end

	// Output register: load a fetched result, drop it when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= rd_a0;
			out_last_q <= cmd.out_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

	// A fetch only lands in an empty output register
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !out_valid_q)
		else $error("result fetched into a full output register");

endmodule

`default_nettype wire

@@ design/xwhc_ctrl.sv @@
// ----------------------------------------------------------------------------
// XOR Walsh-Hadamard convolution controller
// Configuration registers, batch sequencer and address generation for
// load, butterfly, multiply, shift and read passes.
// ----------------------------------------------------------------------------
`default_nettype none

module xwhc_ctrl import xwhc_pkg::*; #(
	parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [CFG_DATA_W-1:0]         cfg_wdata,
	input  wire logic                          in_valid,
	input  wire logic                          in_req_type,
	output logic                               in_ready,
	input  wire logic                          out_valid,
	input  wire logic                          out_ready,
	output cmd_t                               cmd,
	output logic      [$clog2(MAX_LENGTH)-1:0] rd_addr0,
	output logic      [$clog2(MAX_LENGTH)-1:0] rd_addr1,
	output logic      [$clog2(MAX_LENGTH)-1:0] wr_addr
);

	localparam int AW      = $clog2(MAX_LENGTH);
	localparam int LOG_MAX = $clog2(MAX_LENGTH + 1) - 1;

	typedef enum logic [11:0] {
		S_LOAD   = 12'b0000_0000_0001,
		S_BF_RD  = 12'b0000_0000_0010,
		S_BF_WU  = 12'b0000_0000_0100,
		S_BF_WV  = 12'b0000_0000_1000,
		S_MUL_RD = 12'b0000_0001_0000,
		S_MUL_P0 = 12'b0000_0010_0000,
		S_MUL_P1 = 12'b0000_0100_0000,
		S_MUL_P2 = 12'b0000_1000_0000,
		S_MUL_WR = 12'b0001_0000_0000,
		S_SH_RD  = 12'b0010_0000_0000,
		S_SH_WR  = 12'b0100_0000_0000,
		S_READ   = 12'b1000_0000_0000
	} state_t;

	typedef enum logic [2:0] {
		PASS_A  = 3'b001,
		PASS_B  = 3'b010,
		PASS_A2 = 3'b100
	} pass_t;

	state_t            state_q, state_d;
	pass_t             pass_q, pass_d;
	logic [MODE_W-1:0] mode_q;
	logic [LOG_W-1:0]  log_size_q;
	logic [AW-1:0]     idx_q, idx_d;
	logic [AW-1:0]     pair_q, pair_d;
	logic [LOG_W-1:0]  stage_q, stage_d;
	logic              fetch_q, fetch_d;
	logic              fetch_last_q, fetch_last_d;

	logic [LOG_W-1:0]  k_eff;
	logic [AW:0]       n_full;
	logic [AW-1:0]     n_m1, half_m1;
	logic [AW-1:0]     h, mask, pair_nx;
	logic [AW-1:0]     j_cur, jh_cur, j_nx, jh_nx;
	logic              idx_last, pair_last, stage_last;
	logic              in_acc, is_load;

	// Length in use, capped at the RAM depth
	assign k_eff = ({1'b0, log_size_q} > 5'(LOG_MAX)) ? LOG_W'(LOG_MAX) : log_size_q;
	assign n_full  = (AW+1)'(1) << k_eff;
	assign n_m1    = AW'(n_full - 1'b1);
	assign half_m1 = n_m1 >> 1;

	// Butterfly pair addresses: insert a zero bit at the stage position
	assign h       = AW'(1) << stage_q;
	assign mask    = h - 1'b1;
	assign pair_nx = pair_q + 1'b1;
	assign j_cur   = ((pair_q & ~mask) << 1) | (pair_q & mask);
	assign jh_cur  = j_cur | h;
	assign j_nx    = ((pair_nx & ~mask) << 1) | (pair_nx & mask);
	assign jh_nx   = j_nx | h;

	assign idx_last   = (idx_q == n_m1);
	assign pair_last  = (pair_q == half_m1);
	assign stage_last = ((stage_q + 1'b1) == k_eff);
	assign in_acc     = in_valid && in_ready;
	assign is_load    = (in_req_type == REQ_LOAD);

	// Sequencer
	always_comb begin
		state_d      = state_q;
		pass_d       = pass_q;
		idx_d        = idx_q;
		pair_d       = pair_q;
		stage_d      = stage_q;
		fetch_d      = 1'b0;
		fetch_last_d = fetch_last_q;
		in_ready     = 1'b0;
		rd_addr0     = idx_q;
		rd_addr1     = jh_cur;
		wr_addr      = idx_q;

		cmd           = '0;
		cmd.wsel      = WSEL_LOAD;
		cmd.mul_op    = MUL_IDLE;
		cmd.src_b     = (pass_q == PASS_B);
		cmd.out_load  = fetch_q;
		cmd.out_last  = fetch_last_q;
		cmd.shift_amt = k_eff;

		case (state_q)
			S_LOAD: begin
				in_ready = 1'b1;
				if (in_acc && is_load) begin
					cmd.we_a = 1'b1;
					cmd.we_b = 1'b1;
					if (idx_last) begin
						idx_d   = '0;
						pair_d  = '0;
						stage_d = '0;
						pass_d  = PASS_A;
						if (k_eff != '0) begin
							state_d = S_BF_RD;
						end else if (mode_q == MODE_CONV) begin
							state_d = S_MUL_RD;
						end else if (mode_q == MODE_INV) begin
							state_d = S_SH_RD;
						end else begin
							state_d = S_READ;
						end
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
			end
			S_BF_RD: begin
				rd_addr0 = j_cur;
				rd_addr1 = jh_cur;
				state_d  = S_BF_WU;
			end
			S_BF_WU: begin
				cmd.wsel = WSEL_SUM;
				cmd.we_a = !cmd.src_b;
				cmd.we_b = cmd.src_b;
				wr_addr  = j_cur;
				state_d  = S_BF_WV;
			end
			S_BF_WV: begin
				cmd.wsel = WSEL_DIFF;
				cmd.we_a = !cmd.src_b;
				cmd.we_b = cmd.src_b;
				wr_addr  = jh_cur;
				rd_addr0 = j_nx;
				rd_addr1 = jh_nx;
				if (!pair_last) begin
					pair_d  = pair_nx;
					state_d = S_BF_WU;
				end else begin
					pair_d = '0;
					if (!stage_last) begin
						stage_d = stage_q + 1'b1;
						state_d = S_BF_RD;
					end else begin
						stage_d = '0;
						idx_d   = '0;
						case (pass_q)
							PASS_A: begin
								if (mode_q == MODE_CONV) begin
									pass_d  = PASS_B;
									state_d = S_BF_RD;
								end else if (mode_q == MODE_INV) begin
									state_d = S_SH_RD;
								end else begin
									state_d = S_READ;
								end
							end
							PASS_B:  state_d = S_MUL_RD;
							PASS_A2: state_d = S_SH_RD;
							default: state_d = S_READ;
						endcase
					end
				end
			end
			S_MUL_RD: state_d = S_MUL_P0;
			S_MUL_P0: begin
				cmd.mul_op = MUL_LO;
				state_d    = S_MUL_P1;
			end
			S_MUL_P1: begin
				cmd.mul_op = MUL_HI_A;
				state_d    = S_MUL_P2;
			end
			S_MUL_P2: begin
				cmd.mul_op = MUL_HI_B;
				state_d    = S_MUL_WR;
			end
			S_MUL_WR: begin
				cmd.wsel = WSEL_PROD;
				cmd.we_a = 1'b1;
				rd_addr0 = idx_q + 1'b1;
				if (idx_last) begin
					idx_d = '0;
					if (k_eff != '0) begin
						pass_d  = PASS_A2;
						pair_d  = '0;
						stage_d = '0;
						state_d = S_BF_RD;
					end else begin
						state_d = S_SH_RD;
					end
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = S_MUL_P0;
				end
			end
			S_SH_RD: state_d = S_SH_WR;
			S_SH_WR: begin
				cmd.wsel = WSEL_SHIFT;
				cmd.we_a = 1'b1;
				rd_addr0 = idx_q + 1'b1;
				if (idx_last) begin
					idx_d   = '0;
					state_d = S_READ;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			S_READ: begin
				in_ready = !fetch_q && (!out_valid || out_ready);
				if (in_acc && !is_load) begin
					fetch_d      = 1'b1;
					fetch_last_d = idx_last;
					if (idx_last) begin
						idx_d   = '0;
						state_d = S_LOAD;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	// State and configuration; any register write restarts the batch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			pass_q       <= PASS_A;
			mode_q       <= MODE_FWD;
			log_size_q   <= LOG_W'(10);
			idx_q        <= '0;
			pair_q       <= '0;
			stage_q      <= '0;
			fetch_q      <= 1'b0;
			fetch_last_q <= 1'b0;
		end else begin
			fetch_q      <= fetch_d;
			fetch_last_q <= fetch_last_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_MODE:     mode_q     <= cfg_wdata[MODE_W-1:0];
					CFG_LOG_SIZE: log_size_q <= cfg_wdata[LOG_W-1:0];
					default: ;
				endcase
				state_q <= S_LOAD;
				pass_q  <= PASS_A;
				idx_q   <= '0;
				pair_q  <= '0;
				stage_q <= '0;
			end else begin
				state_q <= state_d;
				pass_q  <= pass_d;
				idx_q   <= idx_d;
				pair_q  <= pair_d;
				stage_q <= stage_d;
			end
		end
	end

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_LOAD && state_q != S_READ) |-> !in_ready)
		else $error("input taken while a batch is being computed");

	a_fetch_single: assert property (@(posedge clk) disable iff (!arst_n)
		fetch_q |=> !fetch_q)
		else $error("result fetches issued back to back");

	a_b_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.we_b |-> (state_q == S_LOAD || pass_q == PASS_B))
		else $error("vector b written outside load or its own transform");

	a_stage_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BF_RD || state_q == S_BF_WU || state_q == S_BF_WV)
		|-> (stage_q < k_eff))
		else $error("butterfly stage beyond the length in use");

endmodule

`default_nettype wire

@@ design/xor_walsh_hadamard_convolution_core.sv @@
// ----------------------------------------------------------------------------
// XOR Walsh-Hadamard transform and XOR convolution core
// Loads n = 2^log_size elements, runs in-place butterflies (forward,
// inverse or xor convolution of two vectors) and streams the results out.
//
//   Channel  Direction  Transaction
//   cfg      in         write mode (index 0) or log_size (index 1)
//   s_*      in         load of an a/b element pair, or request for a result
//   m_*      out        one result element, tlast on element n-1
//
// Loads are taken back to back; a read request waits on a pending fetch.
// After the last load the batch runs the butterflies of each transform
// (a butterfly writes its two results in turn via the single write port
// of each work RAM), then the element-wise product and final shift as
// the mode needs. s_tready stays low while the batch computes. Reset
// clears control only; RAM contents are undefined until loaded. A stalled
// m_tready holds the result register and blocks the next read request.
// ----------------------------------------------------------------------------
`default_nettype none

module xor_walsh_hadamard_convolution_core import xwhc_pkg::*; #(
	parameter int MAX_LENGTH = MAX_LENGTH_DEF,
	parameter int INPUT_BITS = INPUT_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0]                 cfg_index,
	input  wire logic [CFG_DATA_W-1:0]                cfg_wdata,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// a_value, b_value (from bit 0 up), zero padded to bytes
	input  wire logic [((2*INPUT_BITS+7)/8)*8-1:0]    s_tdata,
	// req_type
	input  wire logic                                 s_tuser,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// result_value
	output logic      [RESULT_W-1:0]                  m_tdata,
	output logic                                      m_tlast
);

	localparam int AW = $clog2(MAX_LENGTH);

	cmd_t          cmd;
	logic [AW-1:0] rd_addr0, rd_addr1, wr_addr;

	xwhc_ctrl #(.MAX_LENGTH(MAX_LENGTH)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (s_tvalid),
		.in_req_type (s_tuser),
		.in_ready    (s_tready),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.cmd         (cmd),
		.rd_addr0    (rd_addr0),
		.rd_addr1    (rd_addr1),
		.wr_addr     (wr_addr)
	);

	xwhc_dpath #(.MAX_LENGTH(MAX_LENGTH), .INPUT_BITS(INPUT_BITS)) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rd_addr0  (rd_addr0),
		.rd_addr1  (rd_addr1),
		.wr_addr   (wr_addr),
		.load_a    (s_tdata[INPUT_BITS-1:0]),
		.load_b    (s_tdata[2*INPUT_BITS-1:INPUT_BITS]),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule

`default_nettype wire
